// ===== rtl/rlbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbe_pkg
// shared types, constants and helpers of the run-length byte encoder
// ----------------------------------------------------------------------------
package rlbe_pkg;

    // count bytes per record (1 to 8)
    localparam int COUNT_BYTES = 4;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 31;
    localparam int IDX_W       = $clog2(COUNT_BYTES + 1);

    // largest run a record may carry
    localparam logic [LEN_W-1:0] RUN_LIMIT = (COUNT_BYTES >= 4) ? {LEN_W{1'b1}} :
        LEN_W'((64'd1 << (8 * COUNT_BYTES)) - 64'd1);

    // record queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
    } t_record;

    // up to two records caused by one input byte
    typedef struct packed {
        logic    has_close;
        t_record close_rec;
        logic    has_flush;
        t_record flush_rec;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // count byte k of a run length, least significant first, zero above bit 31
    function automatic logic [7:0] count_byte(input logic [LEN_W-1:0] len,
                                              input logic [IDX_W-1:0] k);
        logic [31:0] w;
        w = {1'b0, len};
        count_byte = 8'(w >> {k, 3'b000});
    endfunction

endpackage

// ===== rtl/rlbe_front.sv =====
// ----------------------------------------------------------------------------
// rlbe_front
// run tracking: takes input bytes and queues finished and flushed runs
// ----------------------------------------------------------------------------
module rlbe_front import rlbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [SYM_W-1:0] i_data,
    input  logic             i_final,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [SYM_W-1:0] r_sym, n_sym;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_open, n_open;

    logic             w_close;
    logic [LEN_W-1:0] w_new_len;

    always_comb begin
        w_close   = r_open && !((i_data == r_sym) && (r_len < RUN_LIMIT));
        w_new_len = (r_open && !w_close) ? r_len + LEN_W'(1) : LEN_W'(1);

        o_entry.has_close     = w_close;
        o_entry.close_rec.sym = r_sym;
        o_entry.close_rec.len = r_len;
        o_entry.has_flush     = i_final;
        o_entry.flush_rec.sym = i_data;
        o_entry.flush_rec.len = w_new_len;
        o_push = i_accept && (w_close || i_final);

        n_sym  = r_sym;
        n_len  = r_len;
        n_open = r_open;
        if (i_accept) begin
            if (i_final) begin
                n_sym  = '0;
                n_len  = '0;
                n_open = 1'b0;
            end else begin
                n_sym  = i_data;
                n_len  = w_new_len;
                n_open = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym  <= '0;
            r_len  <= '0;
            r_open <= 1'b0;
        end else begin
            r_sym  <= n_sym;
            r_len  <= n_len;
            r_open <= n_open;
        end
    end

endmodule

// ===== rtl/rlbe_queue.sv =====
// ----------------------------------------------------------------------------
// rlbe_queue
// short circular queue of record entries between front and back
// ----------------------------------------------------------------------------
module rlbe_queue import rlbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;

    logic w_push, w_pop;

    always_comb begin
        o_status.full  = (r_count == Q_CW'(Q_DEPTH));
        o_status.empty = (r_count == '0);
        o_head         = r_mem[r_rd_ptr];

        w_push = i_push && !o_status.full;
        w_pop  = i_pop && !o_status.empty;

        n_wr_ptr = w_push ? r_wr_ptr + Q_AW'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + Q_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/rlbe_back.sv =====
// ----------------------------------------------------------------------------
// rlbe_back
// record serialiser: turns queued entries into symbol and count bytes
// ----------------------------------------------------------------------------
module rlbe_back import rlbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_head_valid,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [7:0]  o_tdata,
    output logic        o_tlast
);

    logic             r_phase, n_phase;   // 0 closing record, 1 flush record
    logic [IDX_W-1:0] r_idx, n_idx;       // 0 symbol, then count bytes
    logic             r_valid, n_valid;
    logic [7:0]       r_data;
    logic             r_last;

    logic             w_load;
    logic             w_sel_flush;
    t_record          w_rec;
    logic [7:0]       w_byte;
    logic             w_rec_end;
    logic             w_entry_end;

    always_comb begin
        w_load      = i_head_valid && (!r_valid || i_tready);
        w_sel_flush = r_phase || !i_head.has_close;
        w_rec       = w_sel_flush ? i_head.flush_rec : i_head.close_rec;
        w_byte      = (r_idx == '0) ? w_rec.sym : count_byte(w_rec.len, r_idx - IDX_W'(1));
        w_rec_end   = (r_idx == IDX_W'(COUNT_BYTES));
        w_entry_end = w_rec_end && (w_sel_flush || !i_head.has_flush);

        o_pop   = w_load && w_entry_end;
        n_phase = r_phase;
        n_idx   = r_idx;
        if (w_load) begin
            if (w_entry_end) begin
                n_phase = 1'b0;
                n_idx   = '0;
            end else if (w_rec_end) begin
                n_phase = 1'b1;
                n_idx   = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end

        n_valid = w_load ? 1'b1 : (i_tready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= w_byte;
            r_last <= w_entry_end;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

// ===== rtl/run_length_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// run-length encoder emitting a symbol byte and a little-endian count per run
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata               tlast
//  s_axis    in   [7:0] data byte     final byte of the stream
//  m_axis    out  [7:0] record byte   last record byte caused by an input
//
//  - the front takes one byte per cycle whenever the record queue is not full
//  - each input that closes or flushes a run queues one entry (one or two records)
//  - the back sends one byte per cycle while not stalled: 1 + COUNT_BYTES bytes per
//    record, so a stream of short runs is paced by the output port
//  - synchronous active-low reset clears run state, queue pointers and output valid
//  - output stalls fill the queue and then hold s_axis_tready low
//
module run_length_byte_encoder import rlbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] data_byte
    input  logic       s_axis_tlast,     // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] out_byte
    output logic       m_axis_tlast      // last_of_burst
);

    logic      w_accept;
    logic      w_push;
    t_entry    w_entry;
    logic      w_pop;
    t_entry    w_head;
    t_q_status w_q_stat;

    // input transfer whenever the queue has a free slot
    assign s_axis_tready = !w_q_stat.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    rlbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_data  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    rlbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_status(w_q_stat)
    );

    // serialiser with its own output register
    rlbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_head_valid(!w_q_stat.empty),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // an entry is never written into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("record entry pushed into full queue");

    // an entry is only retired while one is held
    a_pop_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("record entry popped from empty queue");

    // every queued entry carries at least one record
    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_entry.has_close || w_entry.has_flush))
        else $error("queued entry carries no record");

    // retiring an entry always loads an end-of-burst byte
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (m_axis_tvalid && m_axis_tlast))
        else $error("entry retired without end-of-burst byte");
`endif

endmodule
